// ----- design/sjf_pkg.sv -----
// Shared constants, types and ordering functions for the shortest-job-first scheduler.
// No dependencies; compiled first.
`default_nettype none

package sjf_pkg;

  localparam int unsigned MaxProcs = 16;
  localparam int unsigned IdxW     = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int unsigned CntW     = $clog2(MaxProcs + 1);
  localparam int unsigned TickW    = 16;
  localparam int unsigned TimeW    = 21;
  localparam int unsigned JobIdW   = 6;

  typedef logic [TickW-1:0]  tick_t;
  typedef logic [TimeW-1:0]  time_t;
  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [CntW-1:0]   cnt_t;
  typedef logic [JobIdW-1:0] job_id_t;

  typedef struct packed {
    idx_t  id;
    tick_t arrival;
    tick_t burst;
  } job_t;

  // Dispatch order: shorter burst, then earlier arrival, then lower id.
  function automatic logic runs_before(job_t a, job_t b);
    logic r;
    if (a.burst != b.burst) begin
      r = a.burst < b.burst;
    end else if (a.arrival != b.arrival) begin
      r = a.arrival < b.arrival;
    end else begin
      r = a.id < b.id;
    end
    return r;
  endfunction

  // Report order: earlier arrival, then shorter burst, then lower id.
  function automatic logic reports_before(job_t a, job_t b);
    logic r;
    if (a.arrival != b.arrival) begin
      r = a.arrival < b.arrival;
    end else if (a.burst != b.burst) begin
      r = a.burst < b.burst;
    end else begin
      r = a.id < b.id;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/sjf_if.sv -----
// Handshake channels of the scheduler: job words in, result words out.
// Depends on sjf_pkg for field widths.
`default_nettype none

interface sjf_job_if;
  import sjf_pkg::*;
  logic  valid;
  logic  ready;
  tick_t arrival;
  tick_t burst;
  logic  last_job;

  modport source (output valid, arrival, burst, last_job, input ready);
  modport sink   (input valid, arrival, burst, last_job, output ready);
endinterface

interface sjf_res_if;
  import sjf_pkg::*;
  logic    valid;
  logic    ready;
  job_id_t job_id;
  tick_t   job_arrival;
  tick_t   job_burst;
  time_t   finish_time;
  time_t   turnaround;
  time_t   waiting;
  logic    last_result;

  modport source (output valid, job_id, job_arrival, job_burst, finish_time, turnaround,
                  waiting, last_result, input ready);
  modport sink   (input valid, job_id, job_arrival, job_burst, finish_time, turnaround,
                  waiting, last_result, output ready);
endinterface

`default_nettype wire

// ----- design/sjf_nonpreemptive_scheduler_core.sv -----
// Non-preemptive shortest-job-first scheduler: job table, scan sequencer, result register.
// Depends on sjf_pkg and the channel interfaces in sjf_if.sv.
//
//   channel  dir  word                                   accepted when
//   job_i    in   arrival, burst, last_job               valid & ready
//   res_o    out  id, arrival, burst, finish, tat, wait  valid & ready
//
// Loading accepts one job word per cycle; ready is high only while loading.
// After the word marked last_job, each of the n jobs costs one scan of the n table entries
// (S_SSCAN) and a dispatch (S_COMMIT); then each result costs a scan (S_RSCAN), a step
// that registers it (S_RPICK) and a wait on the output (S_SEND) until it is taken.
// The single compare unit reads one table entry a cycle during these scans.
// Reset (asynchronous, active low) empties the table; a stalled result simply holds.
`default_nettype none

module sjf_nonpreemptive_scheduler_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  sjf_job_if.sink    job_i,
  sjf_res_if.source  res_o
);
  import sjf_pkg::*;

  typedef enum logic [5:0] {
    S_LOAD   = 6'b000001,
    S_SSCAN  = 6'b000010,
    S_COMMIT = 6'b000100,
    S_RSCAN  = 6'b001000,
    S_RPICK  = 6'b010000,
    S_SEND   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  cnt_t   cnt_q, cnt_d;
  cnt_t   left_q, left_d;
  idx_t   idx_q, idx_d;
  time_t  clk_q, clk_d;
  logic   have_a_q, have_a_d;
  logic   have_p_q, have_p_d;
  logic [MaxProcs-1:0] done_q, done_d;

  tick_t arrival_q [MaxProcs];
  tick_t burst_q   [MaxProcs];
  time_t finish_q  [MaxProcs];

  job_t best_a_q, best_p_q;

  job_id_t res_id_q;
  tick_t   res_arr_q, res_bur_q;
  time_t   res_fin_q, res_tat_q, res_wt_q;
  logic    res_last_q;

  logic  acc_in, acc_out, not_full, scan_end, eligible, arrived, take_a, take_p;
  job_t  cur, pick;
  time_t start, fin, rep_fin, rep_tat;
  cnt_t  cnt_after;

  assign acc_in  = job_i.valid && job_i.ready;
  assign acc_out = res_o.valid && res_o.ready;

  assign not_full  = cnt_q != CntW'(MaxProcs);
  assign cnt_after = not_full ? cnt_q + CntW'(1) : cnt_q;

  // Shared compare unit: one table entry against the running bests each cycle.
  assign cur      = '{id: idx_q, arrival: arrival_q[idx_q], burst: burst_q[idx_q]};
  assign eligible = (state_q == S_RSCAN) ? done_q[idx_q] : !done_q[idx_q];
  assign arrived  = TimeW'(cur.arrival) <= clk_q;
  assign take_a   = (state_q == S_SSCAN) && eligible && arrived &&
                    (!have_a_q || runs_before(cur, best_a_q));
  assign take_p   = eligible && (!have_p_q || reports_before(cur, best_p_q));
  assign scan_end = CntW'(idx_q) == cnt_q - CntW'(1);

  // No job has arrived: jump the clock to the earliest pending arrival.
  assign pick  = have_a_q ? best_a_q : best_p_q;
  assign start = have_a_q ? clk_q : TimeW'(best_p_q.arrival);
  assign fin   = start + TimeW'(pick.burst);

  assign rep_fin = finish_q[best_p_q.id];
  assign rep_tat = rep_fin - TimeW'(best_p_q.arrival);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    left_d   = left_q;
    idx_d    = idx_q;
    clk_d    = clk_q;
    have_a_d = have_a_q;
    have_p_d = have_p_q;
    done_d   = done_q;
    unique case (state_q)
      S_LOAD: begin
        if (acc_in) begin
          if (not_full) begin
            done_d[cnt_q[IdxW-1:0]] = 1'b0;
          end
          cnt_d = cnt_after;
          if (job_i.last_job) begin
            state_d  = S_SSCAN;
            left_d   = cnt_after;
            idx_d    = '0;
            clk_d    = '0;
            have_a_d = 1'b0;
            have_p_d = 1'b0;
          end
        end
      end
      S_SSCAN, S_RSCAN: begin
        if (take_a) have_a_d = 1'b1;
        if (take_p) have_p_d = 1'b1;
        idx_d = idx_q + IdxW'(1);
        if (scan_end) begin
          state_d = (state_q == S_SSCAN) ? S_COMMIT : S_RPICK;
        end
      end
      S_COMMIT: begin
        done_d[pick.id] = 1'b1;
        clk_d    = fin;
        idx_d    = '0;
        have_a_d = 1'b0;
        have_p_d = 1'b0;
        if (left_q == CntW'(1)) begin
          state_d = S_RSCAN;
          left_d  = cnt_q;
        end else begin
          state_d = S_SSCAN;
          left_d  = left_q - CntW'(1);
        end
      end
      S_RPICK: begin
        // reported jobs drop their done mark, which leaves the table clear at the end
        done_d[best_p_q.id] = 1'b0;
        left_d  = left_q - CntW'(1);
        state_d = S_SEND;
      end
      S_SEND: begin
        if (acc_out) begin
          idx_d    = '0;
          have_p_d = 1'b0;
          if (res_last_q) begin
            state_d = S_LOAD;
            cnt_d   = '0;
          end else begin
            state_d = S_RSCAN;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      cnt_q    <= '0;
      left_q   <= '0;
      idx_q    <= '0;
      clk_q    <= '0;
      have_a_q <= 1'b0;
      have_p_q <= 1'b0;
      done_q   <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      left_q   <= left_d;
      idx_q    <= idx_d;
      clk_q    <= clk_d;
      have_a_q <= have_a_d;
      have_p_q <= have_p_d;
      done_q   <= done_d;
    end
  end

  // Table and payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD && acc_in && not_full) begin
      arrival_q[cnt_q[IdxW-1:0]] <= job_i.arrival;
      burst_q[cnt_q[IdxW-1:0]]   <= job_i.burst;
    end
    if (state_q == S_COMMIT) begin
      finish_q[pick.id] <= fin;
    end
    if (take_a) best_a_q <= cur;
    if (take_p) best_p_q <= cur;
    if (state_q == S_RPICK) begin
      res_id_q   <= JobIdW'(best_p_q.id);
      res_arr_q  <= best_p_q.arrival;
      res_bur_q  <= best_p_q.burst;
      res_fin_q  <= rep_fin;
      res_tat_q  <= rep_tat;
      res_wt_q   <= rep_tat - TimeW'(best_p_q.burst);
      res_last_q <= left_q == CntW'(1);
    end
  end

  assign job_i.ready       = state_q == S_LOAD;
  assign res_o.valid       = state_q == S_SEND;
  assign res_o.job_id      = res_id_q;
  assign res_o.job_arrival = res_arr_q;
  assign res_o.job_burst   = res_bur_q;
  assign res_o.finish_time = res_fin_q;
  assign res_o.turnaround  = res_tat_q;
  assign res_o.waiting     = res_wt_q;
  assign res_o.last_result = res_last_q;

  // Loading and reporting never overlap.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(job_i.ready && res_o.valid))
    else $error("job and result channels active together");

  // Every dispatch has a candidate job.
  a_commit_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COMMIT |-> (have_a_q || have_p_q))
    else $error("dispatch without a candidate");

  // The final result leaves an empty table.
  a_run_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_out && res_o.last_result) |=> (cnt_q == '0 && done_q == '0))
    else $error("table not clear after run");

  // Waiting plus burst gives turnaround.
  a_times: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (time_t'(res_o.waiting + TimeW'(res_o.job_burst)) == res_o.turnaround))
    else $error("inconsistent result times");

endmodule

`default_nettype wire

// ----- tb/sjf_nonpreemptive_scheduler_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the shortest-job-first scheduler core: sends job words, predicts
// every result word from its own schedule and checks them in order. Needs sjf_pkg and sjf_if.sv.

module sjf_nonpreemptive_scheduler_core_tb;
  import sjf_pkg::*;

  // Drain allowance for a full set, with a margin on top.
  localparam int unsigned DrainCycles = 2 * MaxProcs * (MaxProcs + 1) + MaxProcs + 64;
  localparam int unsigned HoldCycles  = 1500;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned ItemsPerPhase = 150;

  typedef struct packed {
    job_id_t id;
    tick_t   arr;
    tick_t   bur;
    time_t   fin;
    time_t   tat;
    time_t   wt;
    logic    end_flag;
  } sched_res_t;

  logic clk_i;
  logic rst_ni;

  sjf_job_if job_ch ();
  sjf_res_if res_ch ();

  sjf_nonpreemptive_scheduler_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .job_i  (job_ch),
    .res_o  (res_ch)
  );

  // Predicted job table
  tick_t arr_tab [MaxProcs];
  tick_t bur_tab [MaxProcs];
  time_t fin_tab [MaxProcs];
  logic  served  [MaxProcs] = '{default: 1'b0};
  int    loaded = 0;
  time_t sched_clock = '0;

  sched_res_t sched_q [$];

  int   mismatches = 0;
  int   cycles = 0;
  int   items_sent = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic rx_hold;
  event hold_go;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic dispatch_first(int a, int b);
    if (bur_tab[a] != bur_tab[b]) return bur_tab[a] < bur_tab[b];
    if (arr_tab[a] != arr_tab[b]) return arr_tab[a] < arr_tab[b];
    return a < b;
  endfunction

  function automatic logic listed_first(int a, int b);
    if (arr_tab[a] != arr_tab[b]) return arr_tab[a] < arr_tab[b];
    if (bur_tab[a] != bur_tab[b]) return bur_tab[a] < bur_tab[b];
    return a < b;
  endfunction

  function automatic int next_runnable(int n, time_t now);
    int pick;
    pick = -1;
    for (int i = 0; i < n; i++)
      if (!served[i] && arr_tab[i] <= now && (pick < 0 || dispatch_first(i, pick)))
        pick = i;
    return pick;
  endfunction

  // Run the set to completion, then queue its results in report order.
  task automatic close_set();
    int n, pick, k;
    int order [MaxProcs];
    time_t now, nxt;
    sched_res_t r;
    n = loaded;
    now = arr_tab[0];
    for (int i = 1; i < n; i++)
      if (arr_tab[i] < now) now = arr_tab[i];
    for (int left = n; left > 0; left--) begin
      pick = next_runnable(n, now);
      if (pick < 0) begin
        // processor idle: jump to the earliest pending arrival
        nxt = '1;
        for (int i = 0; i < n; i++)
          if (!served[i] && arr_tab[i] < nxt) nxt = arr_tab[i];
        now = nxt;
        pick = next_runnable(n, now);
      end
      if (pick < 0) break;
      now = now + bur_tab[pick];
      fin_tab[pick] = now;
      served[pick] = 1'b1;
    end
    sched_clock = now;
    for (int i = 0; i < n; i++) begin
      k = i;
      while (k > 0 && listed_first(i, order[k-1])) begin
        order[k] = order[k-1];
        k--;
      end
      order[k] = i;
    end
    for (int i = 0; i < n; i++) begin
      k = order[i];
      r.id       = job_id_t'(k);
      r.arr      = arr_tab[k];
      r.bur      = bur_tab[k];
      r.fin      = fin_tab[k];
      r.tat      = fin_tab[k] - arr_tab[k];
      r.wt       = r.tat - bur_tab[k];
      r.end_flag = (i == n - 1);
      sched_q.push_back(r);
    end
    loaded = 0;
    served = '{default: 1'b0};
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && job_ch.valid && job_ch.ready) begin
      // drop the word once the table is full
      if (loaded < MaxProcs) begin
        arr_tab[loaded] = job_ch.arrival;
        bur_tab[loaded] = job_ch.burst;
        served[loaded]  = 1'b0;
        loaded++;
      end
      if (job_ch.last_job && loaded > 0) close_set();
    end
  end

  always @(posedge clk_i) begin : check_results
    sched_res_t got, want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = {res_ch.job_id, res_ch.job_arrival, res_ch.job_burst, res_ch.finish_time,
             res_ch.turnaround, res_ch.waiting, res_ch.last_result};
      if (sched_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result word: id %0d arr %0d bur %0d fin %0d", $time,
                   got.id, got.arr, got.bur, got.fin);
      end else begin
        want = sched_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result word mismatch", $time);
            $display("  expected id %0d arr %0d bur %0d fin %0d tat %0d wait %0d last %0b",
                     want.id, want.arr, want.bur, want.fin, want.tat, want.wt, want.end_flag);
            $display("  actual   id %0d arr %0d bur %0d fin %0d tat %0d wait %0d last %0b",
                     got.id, got.arr, got.bur, got.fin, got.tat, got.wt, got.end_flag);
          end
        end
      end
    end
  end

  always @(negedge clk_i)
    res_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);

  // Hold the result side off for a long stretch when asked.
  initial begin
    rx_hold = 1'b0;
    forever begin
      @(hold_go);
      rx_hold = 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      rx_hold = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_job(tick_t arrival, tick_t burst, logic last_job);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      job_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    job_ch.valid    = 1'b1;
    job_ch.arrival  = arrival;
    job_ch.burst    = burst;
    job_ch.last_job = last_job;
    do @(posedge clk_i); while (!job_ch.ready);
    items_sent++;
  endtask

  function automatic tick_t pick_tick(int style);
    case (style)
      0:       return tick_t'($urandom_range(0, 7));
      1:       return tick_t'($urandom_range(0, 300));
      default: return tick_t'($urandom);
    endcase
  endfunction

  // One set with random content; sizes past the table end on an ignored last word.
  task automatic send_random_set();
    int roll, size, arr_style, bur_style;
    roll = $urandom_range(99);
    if (roll < 65)      size = $urandom_range(1, 6);
    else if (roll < 90) size = $urandom_range(7, MaxProcs);
    else                size = $urandom_range(MaxProcs + 1, MaxProcs + 4);
    arr_style = $urandom_range(2);
    bur_style = $urandom_range(2);
    for (int j = 0; j < size; j++)
      send_job(pick_tick(arr_style), pick_tick(bur_style), j == size - 1);
  endtask

  task automatic test_zero_burst();
    send_job(16'd42, 16'd0, 1'b1);
  endtask

  task automatic test_clock_jump();
    send_job(16'd10, 16'd5, 1'b0);
    send_job(16'd100, 16'd3, 1'b0);
    send_job(16'd101, 16'd1, 1'b1);
  endtask

  task automatic test_tie_breaks();
    send_job(16'd5, 16'd4, 1'b0);
    send_job(16'd5, 16'd4, 1'b0);
    send_job(16'd3, 16'd4, 1'b1);
  endtask

  // Fill the table with mostly the widest values, then close on a word that is ignored.
  task automatic test_table_full();
    for (int j = 0; j < MaxProcs; j++) begin
      if (j == 0)                 send_job(16'd0, 16'hFFFF, 1'b0);
      else if (j == MaxProcs - 1) send_job(16'hFFFF, 16'd0, 1'b0);
      else                        send_job(16'hFFFF, 16'hFFFF, 1'b0);
    end
    send_job(16'h1234, 16'h00FF, 1'b1);
  endtask

  task automatic test_random(int s_pct, int r_pct);
    int target;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    target = items_sent + ItemsPerPhase;
    while (items_sent < target) send_random_set();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk_i);
    -> hold_go;
    for (int j = 0; j < MaxProcs; j++)
      send_job(pick_tick(1), pick_tick(1), j == MaxProcs - 1);
    for (int j = 0; j < 5; j++)
      send_job(pick_tick(0), pick_tick(0), j == 4);
  endtask

  initial begin
    rst_ni          = 1'b0;
    job_ch.valid    = 1'b0;
    job_ch.arrival  = '0;
    job_ch.burst    = '0;
    job_ch.last_job = 1'b0;
    send_idle_pct   = 31;
    recv_idle_pct   = 75;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    test_zero_burst();
    test_clock_jump();
    test_tie_breaks();
    test_table_full();
    test_random(31, 75);
    test_random(75, 31);
    test_backpressure();
    test_random(0, 0);

    @(negedge clk_i) job_ch.valid = 1'b0;
    while (sched_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
